### rtl/core/nrmc_pkg.sv
// ============================================================================
// nrmc_pkg: shared types and constants of the RMC position parser
// Character codes, field numbers, fixed-point widths and the constant
// tables used by the coordinate conversion pipeline.
// ============================================================================
package nrmc_pkg;

    // Operation codes of the input channel
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Fraction digits kept per coordinate (1..7)
    localparam int FRAC_DIGITS = 5;

    // Character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_S = 8'h53;
    localparam logic [7:0] CH_UPPER_W = 8'h57;

    // Field numbers within the sentence
    localparam logic [3:0] FLD_STATUS = 4'd2;
    localparam logic [3:0] FLD_LAT    = 4'd3;
    localparam logic [3:0] FLD_NS     = 4'd4;
    localparam logic [3:0] FLD_LON    = 4'd5;
    localparam logic [3:0] FLD_EW     = 4'd6;
    localparam logic [3:0] FLD_LAST   = 4'd15;

    // Widths
    localparam int ACC_W  = 40;  // digit accumulator
    localparam int FRAC_W = 3;   // fraction digit count
    localparam int POW_W  = 24;  // 10^0 .. 10^7
    localparam int A_W    = 38;  // accumulator scaled to 1e-7 minutes units
    localparam int DEG_W  = 8;   // whole degrees, at most 180
    localparam int MIN_W  = 30;  // remainder below one degree
    localparam int QUO_W  = 24;  // remainder in 1e-7 degrees
    localparam int MAG_W  = 31;  // unsigned result magnitude

    localparam logic [FRAC_W-1:0] MAX_FE = 3'd7;
    localparam logic [ACC_W-1:0]  INT_SAT = 40'd99999;

    // floor(x / 1953125) = (x * DEG_RECIP) >> DEG_SHIFT for x < 2^29
    localparam int DEG_PRE     = 9;
    localparam int DEG_RECIP_W = 31;
    localparam logic [DEG_RECIP_W-1:0] DEG_RECIP = 31'd1152921505;
    localparam int DEG_SHIFT   = 51;

    // floor(x / 15) = (x * MIN_RECIP) >> MIN_SHIFT for x < 2^28
    localparam int MIN_PRE     = 2;
    localparam int MIN_RECIP_W = 29;
    localparam logic [MIN_RECIP_W-1:0] MIN_RECIP = 29'd286331154;
    localparam int MIN_SHIFT   = 32;

    localparam logic [MIN_W-1:0] E9 = 30'd1000000000;
    localparam logic [POW_W-1:0] E7 = 24'd10000000;

    localparam logic [MAG_W-1:0] LAT_LIMIT = 31'd900000000;
    localparam logic [MAG_W-1:0] LON_LIMIT = 31'd1800000000;

    typedef enum logic [1:0] {
        EVT_READ,
        EVT_FIX,
        EVT_VOID
    } evt_kind_t;

    typedef struct packed {
        evt_kind_t kind;
        logic      south;
        logic      west;
    } evt_t;

    // Load enables of the four conversion stages
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } conv_ld_t;

    typedef struct packed {
        logic [ACC_W-1:0]  acc;
        logic              in_frac;
        logic [FRAC_W-1:0] frac;
    } coord_upd_t;

    function automatic logic [7:0] rmc_tag(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h24;  // $
            3'd1:    ch = 8'h47;  // G
            3'd2:    ch = 8'h50;  // P
            3'd3:    ch = 8'h52;  // R
            3'd4:    ch = 8'h4D;  // M
            3'd5:    ch = 8'h43;  // C
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [POW_W-1:0] pow10(input logic [FRAC_W-1:0] e);
        logic [POW_W-1:0] p;
        unique case (e)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            default: p = 24'd10000000;
        endcase
        return p;
    endfunction

    // 181 degrees expressed in accumulator units for fe fraction digits
    function automatic logic [ACC_W-1:0] over_thr(input logic [FRAC_W-1:0] fe);
        logic [ACC_W-1:0] t;
        unique case (fe)
            3'd0:    t = 40'd18100;
            3'd1:    t = 40'd181000;
            3'd2:    t = 40'd1810000;
            3'd3:    t = 40'd18100000;
            3'd4:    t = 40'd181000000;
            3'd5:    t = 40'd1810000000;
            3'd6:    t = 40'd18100000000;
            default: t = 40'd181000000000;
        endcase
        return t;
    endfunction

endpackage

### rtl/core/nrmc_coord_conv.sv
// ============================================================================
// nrmc_coord_conv: four-stage ddmm.mmmm to 1e-7 degree conversion
// Scales the accumulator to a common fraction, splits degrees and minutes
// by reciprocal multiplication and converts minutes to degree units.
// ============================================================================
module nrmc_coord_conv (
    input  logic                            aclk,
    input  nrmc_pkg::conv_ld_t              ld,
    input  logic [nrmc_pkg::ACC_W-1:0]      acc_i,
    input  logic [nrmc_pkg::FRAC_W-1:0]     fe_i,
    output logic [nrmc_pkg::MAG_W-1:0]      mag_o,
    output logic                            over_o
);
    import nrmc_pkg::*;

    localparam int SCL_P_W = A_W + POW_W;
    localparam int DEG_P_W = A_W - DEG_PRE + DEG_RECIP_W;
    localparam int MIN_P_W = MIN_W - MIN_PRE + MIN_RECIP_W;

    logic [SCL_P_W-1:0] scale_prod;
    logic [A_W-1:0]     a1_next;
    logic               over1_next;
    logic [DEG_P_W-1:0] deg_prod;
    logic [A_W-1:0]     deg_scaled;
    logic [A_W-1:0]     rem_full;
    logic [MIN_P_W-1:0] min_prod;

    logic [A_W-1:0]   a1_reg, a2_reg;
    logic             over1_reg, over2_reg, over3_reg, over4_reg;
    logic [DEG_W-1:0] deg2_reg, deg3_reg, deg4_reg;
    logic [MIN_W-1:0] m3_reg;
    logic [QUO_W-1:0] q4_reg;

    // Stage 1: bring the value to seven fraction digits
    assign scale_prod = SCL_P_W'(acc_i[A_W-1:0]) * SCL_P_W'(pow10(MAX_FE - fe_i));
    assign a1_next    = scale_prod[A_W-1:0];
    assign over1_next = (acc_i >= over_thr(fe_i));

    // Stage 2: whole degrees
    assign deg_prod = DEG_P_W'(a1_reg[A_W-1:DEG_PRE]) * DEG_P_W'(DEG_RECIP);

    // Stage 3: remainder below one degree
    assign deg_scaled = A_W'(deg2_reg) * A_W'(E9);
    assign rem_full   = a2_reg - deg_scaled;

    // Stage 4: minutes over sixty
    assign min_prod = MIN_P_W'(m3_reg[MIN_W-1:MIN_PRE]) * MIN_P_W'(MIN_RECIP);

    always_ff @(posedge aclk) begin
        if (ld.ld1) begin
            a1_reg    <= a1_next;
            over1_reg <= over1_next;
        end
        if (ld.ld2) begin
            a2_reg    <= a1_reg;
            deg2_reg  <= deg_prod[DEG_SHIFT +: DEG_W];
            over2_reg <= over1_reg;
        end
        if (ld.ld3) begin
            m3_reg    <= rem_full[MIN_W-1:0];
            deg3_reg  <= deg2_reg;
            over3_reg <= over2_reg;
        end
        if (ld.ld4) begin
            q4_reg    <= min_prod[MIN_SHIFT +: QUO_W];
            deg4_reg  <= deg3_reg;
            over4_reg <= over3_reg;
        end
    end

    assign mag_o  = MAG_W'(deg4_reg) * MAG_W'(E7) + MAG_W'(q4_reg);
    assign over_o = over4_reg;

endmodule

### rtl/core/nmea_rmc_position_parser_top.sv
// ============================================================================
// nmea_rmc_position_parser_top: RMC sentence position parser
// Parses $GPRMC sentences byte by byte and hands out the latest valid fix
// in 1e-7 degree units on a read request.
// ============================================================================
//
//  Channel | Ports                                    | Beat carries
//  --------+------------------------------------------+---------------------------
//  input   | s_valid s_ready s_operation s_rx_byte    | one byte or a read request
//  result  | m_valid m_ready m_fix_new m_latitude_e7  | one result per read request
//          | m_longitude_e7                           |
//
//  One input beat per cycle while s_ready is high. Bytes update the parser
//  in the cycle they are taken; the edge that accepts a read loads the first
//  of four conversion stages (scale, degree split, remainder, minutes), and
//  the read passes through the others in turn before it loads the output
//  register. Line ends and reads travel the conversion pipeline in order, so
//  a read always sees the fix of every sentence ended before it.
//  Reset is synchronous and active low. A stalled result holds the output
//  register; up to four more line ends or reads queue in the pipeline before
//  s_ready drops.
//
module nmea_rmc_position_parser_top #(
    parameter int MAX_LINE = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_fix_new,
    output logic signed [30:0] m_latitude_e7,
    output logic signed [31:0] m_longitude_e7
);
    import nrmc_pkg::*;

    localparam int LEN_W = $clog2(MAX_LINE);
    localparam int NSTG  = 4;

    // Parser state
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              discard_reg, discard_next;
    logic              prefix_reg, prefix_next;
    logic [3:0]        field_reg, field_next;
    logic              active_reg, active_next;
    logic [ACC_W-1:0]  lat_acc_reg, lat_acc_next;
    logic [ACC_W-1:0]  lon_acc_reg, lon_acc_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic              in_frac_reg, in_frac_next;
    logic              south_reg, south_next;
    logic              west_reg, west_next;

    logic       take_beat;
    logic       take_byte;
    logic       finish_evt;
    coord_upd_t coord_upd;

    // Pipeline control
    logic [NSTG:1] vld_reg;
    logic [NSTG:1] rdy;
    evt_t          evt_reg [NSTG:1];
    evt_t          evt_in;
    logic          evt_in_vld;
    logic          out_rdy;
    logic          fire;
    conv_ld_t      conv_ld;

    // Conversion results and stored fix
    logic [MAG_W-1:0] lat_mag, lon_mag;
    logic             lat_over, lon_over;
    logic [MAG_W-1:0] lat_abs, lon_abs;
    logic [30:0]      lat_val;
    logic [31:0]      lon_val;
    logic [30:0]      fix_lat_reg;
    logic [31:0]      fix_lon_reg;
    logic             quality_reg;
    logic             pending_reg;
    logic             read_hit;

    // Result register
    logic        m_valid_reg;
    logic        m_fix_new_reg;
    logic [30:0] m_lat_reg;
    logic [31:0] m_lon_reg;

    // Digit accumulation for one coordinate character
    function automatic coord_upd_t coord_step(
        input logic [ACC_W-1:0]  acc,
        input logic [7:0]        c,
        input logic              in_frac,
        input logic [FRAC_W-1:0] frac
    );
        coord_upd_t       u;
        logic [ACC_W+3:0] n;
        u.acc     = acc;
        u.in_frac = in_frac;
        u.frac    = frac;
        n = ((ACC_W+4)'(acc) << 3) + ((ACC_W+4)'(acc) << 1) + (ACC_W+4)'(c[3:0]);
        if (c == CH_DOT) begin
            u.in_frac = 1'b1;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            if (!in_frac) begin
                // Saturate the whole part
                u.acc = (n > (ACC_W+4)'(INT_SAT)) ? INT_SAT : n[ACC_W-1:0];
            end else if (frac < FRAC_W'(FRAC_DIGITS)) begin
                // Drop digits past the kept fraction
                u.acc  = n[ACC_W-1:0];
                u.frac = frac + 1'b1;
            end
        end
        return u;
    endfunction

    // ------------------------------------------------------------------
    // Handshake and pipeline flow: a stage advances when the next one
    // is empty or advancing; fix updates retire without the output.
    // ------------------------------------------------------------------
    assign out_rdy   = !m_valid_reg || m_ready;
    assign fire      = vld_reg[NSTG] && (evt_reg[NSTG].kind != EVT_READ || out_rdy);
    assign s_ready   = rdy[1];
    assign take_beat = s_valid && s_ready;
    assign take_byte = take_beat && (s_operation == OP_BYTE);

    always_comb begin
        rdy[NSTG] = !vld_reg[NSTG] || fire;
        for (int i = NSTG - 1; i >= 1; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign conv_ld.ld1 = rdy[1];
    assign conv_ld.ld2 = rdy[2];
    assign conv_ld.ld3 = rdy[3];
    assign conv_ld.ld4 = rdy[4];

    // ------------------------------------------------------------------
    // Sentence parser: while s_ready is high, one byte per cycle
    // ------------------------------------------------------------------
    always_comb begin
        len_next     = len_reg;
        discard_next = discard_reg;
        prefix_next  = prefix_reg;
        field_next   = field_reg;
        active_next  = active_reg;
        lat_acc_next = lat_acc_reg;
        lon_acc_next = lon_acc_reg;
        frac_next    = frac_reg;
        in_frac_next = in_frac_reg;
        south_next   = south_reg;
        west_next    = west_reg;
        finish_evt   = 1'b0;
        coord_upd    = coord_step(lat_acc_reg, s_rx_byte, in_frac_reg, frac_reg);

        if (take_byte) begin
            if (s_rx_byte == CH_DOLLAR) begin
                // Start (or restart) a sentence
                len_next     = LEN_W'(1);
                discard_next = 1'b0;
                prefix_next  = 1'b1;
                field_next   = '0;
                active_next  = 1'b0;
                lat_acc_next = '0;
                lon_acc_next = '0;
                frac_next    = '0;
                in_frac_next = 1'b0;
                south_next   = 1'b0;
                west_next    = 1'b0;
            end else if (s_rx_byte == CH_CR || s_rx_byte == CH_LF) begin
                // Close the line; only a complete RMC header reports
                if (!discard_reg && len_reg != '0 && prefix_reg
                        && len_reg >= LEN_W'(6)) begin
                    finish_evt = 1'b1;
                end
                len_next     = '0;
                discard_next = 1'b1;
            end else if (!discard_reg) begin
                if (len_reg >= LEN_W'(MAX_LINE - 1)) begin
                    // Over-long line: drop until the next dollar
                    discard_next = 1'b1;
                    len_next     = '0;
                end else begin
                    len_next = len_reg + 1'b1;
                    if (len_reg < LEN_W'(6) && s_rx_byte != rmc_tag(len_reg[2:0])) begin
                        prefix_next = 1'b0;
                    end
                    if (s_rx_byte == CH_COMMA) begin
                        if (field_reg != FLD_LAST) begin
                            field_next = field_reg + 1'b1;
                        end
                        in_frac_next = 1'b0;
                        frac_next    = '0;
                    end else begin
                        case (field_reg)
                            FLD_STATUS: begin
                                if (!in_frac_reg) begin
                                    if (s_rx_byte == CH_UPPER_A) begin
                                        active_next = 1'b1;
                                    end
                                    in_frac_next = 1'b1;
                                end
                            end
                            FLD_LAT: begin
                                lat_acc_next = coord_upd.acc;
                                in_frac_next = coord_upd.in_frac;
                                frac_next    = coord_upd.frac;
                            end
                            FLD_NS: begin
                                if (!in_frac_reg) begin
                                    south_next   = (s_rx_byte == CH_UPPER_S);
                                    in_frac_next = 1'b1;
                                end
                            end
                            FLD_LON: begin
                                coord_upd = coord_step(lon_acc_reg, s_rx_byte,
                                                       in_frac_reg, frac_reg);
                                lon_acc_next = coord_upd.acc;
                                in_frac_next = coord_upd.in_frac;
                                frac_next    = coord_upd.frac;
                            end
                            FLD_EW: begin
                                if (!in_frac_reg) begin
                                    west_next    = (s_rx_byte == CH_UPPER_W);
                                    in_frac_next = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            discard_reg <= 1'b1;
            prefix_reg  <= 1'b0;
            field_reg   <= '0;
            active_reg  <= 1'b0;
            lat_acc_reg <= '0;
            lon_acc_reg <= '0;
            frac_reg    <= '0;
            in_frac_reg <= 1'b0;
            south_reg   <= 1'b0;
            west_reg    <= 1'b0;
        end else begin
            len_reg     <= len_next;
            discard_reg <= discard_next;
            prefix_reg  <= prefix_next;
            field_reg   <= field_next;
            active_reg  <= active_next;
            lat_acc_reg <= lat_acc_next;
            lon_acc_reg <= lon_acc_next;
            frac_reg    <= frac_next;
            in_frac_reg <= in_frac_next;
            south_reg   <= south_next;
            west_reg    <= west_next;
        end
    end

    // ------------------------------------------------------------------
    // Event entry: reads and reported line ends enter the pipeline.
    // The accumulators are still intact in the line-end cycle.
    // ------------------------------------------------------------------
    assign evt_in_vld = take_beat && (s_operation == OP_READ || finish_evt);

    always_comb begin
        evt_in.south = south_reg;
        evt_in.west  = west_reg;
        if (s_operation == OP_READ) begin
            evt_in.kind = EVT_READ;
        end else if (active_reg) begin
            evt_in.kind = EVT_FIX;
        end else begin
            evt_in.kind = EVT_VOID;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[1]) begin
                vld_reg[1] <= evt_in_vld;
            end
            for (int i = 2; i <= NSTG; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            evt_reg[1] <= evt_in;
        end
        for (int i = 2; i <= NSTG; i++) begin
            if (rdy[i]) begin
                evt_reg[i] <= evt_reg[i-1];
            end
        end
    end

    nrmc_coord_conv u_lat_conv (
        .aclk   (aclk),
        .ld     (conv_ld),
        .acc_i  (lat_acc_reg),
        .fe_i   (frac_reg),
        .mag_o  (lat_mag),
        .over_o (lat_over)
    );

    nrmc_coord_conv u_lon_conv (
        .aclk   (aclk),
        .ld     (conv_ld),
        .acc_i  (lon_acc_reg),
        .fe_i   (frac_reg),
        .mag_o  (lon_mag),
        .over_o (lon_over)
    );

    // ------------------------------------------------------------------
    // Last stage: clamp, apply hemisphere, update the stored fix and
    // answer reads in arrival order.
    // ------------------------------------------------------------------
    assign lat_abs = (lat_over || lat_mag > LAT_LIMIT) ? LAT_LIMIT : lat_mag;
    assign lon_abs = (lon_over || lon_mag > LON_LIMIT) ? LON_LIMIT : lon_mag;
    assign lat_val = evt_reg[NSTG].south ? (31'd0 - lat_abs) : lat_abs;
    assign lon_val = evt_reg[NSTG].west  ? (32'd0 - {1'b0, lon_abs}) : {1'b0, lon_abs};
    assign read_hit = pending_reg && quality_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quality_reg <= 1'b0;
            pending_reg <= 1'b0;
        end else if (fire) begin
            case (evt_reg[NSTG].kind)
                EVT_FIX: begin
                    quality_reg <= 1'b1;
                    pending_reg <= 1'b1;
                end
                EVT_VOID: begin
                    quality_reg <= 1'b0;
                end
                EVT_READ: begin
                    // Hand out the fix once
                    if (read_hit) begin
                        pending_reg <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && evt_reg[NSTG].kind == EVT_FIX) begin
            fix_lat_reg <= lat_val;
            fix_lon_reg <= lon_val;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_rdy) begin
            m_valid_reg <= fire && evt_reg[NSTG].kind == EVT_READ;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && evt_reg[NSTG].kind == EVT_READ) begin
            m_fix_new_reg <= read_hit;
            m_lat_reg     <= read_hit ? fix_lat_reg : '0;
            m_lon_reg     <= read_hit ? fix_lon_reg : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_fix_new      = m_fix_new_reg;
    assign m_latitude_e7  = m_lat_reg;
    assign m_longitude_e7 = m_lon_reg;

endmodule

### rtl/core/nrmc_checker.sv
// ============================================================================
// nrmc_checker: port-level checks of the RMC position parser
// Watches the result channel for hold behavior, zero coordinates without a new fix and value ranges.
// ============================================================================
module nrmc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_fix_new,
    input logic signed [30:0] m_latitude_e7,
    input logic signed [31:0] m_longitude_e7
);

    // Hold a stalled result beat
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fix_new)
            && $stable(m_latitude_e7) && $stable(m_longitude_e7))
        else $error("result beat changed while stalled");

    // A read without a new fix returns zero coordinates
    a_zero_no_fix: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_fix_new |-> m_latitude_e7 == 31'sd0 && m_longitude_e7 == 32'sd0)
        else $error("coordinates nonzero without a new fix");

    a_lat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_latitude_e7 >= -31'sd900000000 && m_latitude_e7 <= 31'sd900000000)
        else $error("latitude out of range");

    a_lon_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_longitude_e7 >= -32'sd1800000000
            && m_longitude_e7 <= 32'sd1800000000)
        else $error("longitude out of range");

endmodule

bind nmea_rmc_position_parser_top nrmc_checker u_nrmc_checker (.*);

### tb/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench: regression for the RMC position parser
// Streams directed and random NMEA traffic with read requests through the
// input channel, predicts every read result from a bit-exact parser model
// kept in the bench, and checks each result beat field by field under random
// idling and stalls on both channels.
// ============================================================================
module testbench;
    import nrmc_pkg::*;

    localparam int          LINE_MAX      = 128;
    localparam int          LIMIT_CYCLES  = 400000;
    localparam int          TAIL_CYCLES   = 20;
    localparam int          ITEM_TARGET   = 1300;
    localparam int          READ_TARGET   = 60;
    localparam int          HOLD_CYCLES   = 300;
    localparam logic [47:0] RMC_TAG       = "$GPRMC";
    localparam longint unsigned COORD_INT_CAP = 64'd99999;
    localparam longint unsigned LAT_CAP       = 64'd900000000;
    localparam longint unsigned LON_CAP       = 64'd1800000000;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
    } rx_item_t;

    typedef struct packed {
        logic        fix_new;
        logic [30:0] lat;
        logic [31:0] lon;
    } fix_report_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------
    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic               s_operation = OP_BYTE;
    logic [7:0]         s_rx_byte   = 8'h00;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic               m_fix_new;
    logic signed [30:0] m_latitude_e7;
    logic signed [31:0] m_longitude_e7;

    nmea_rmc_position_parser_top #(
        .MAX_LINE(LINE_MAX)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_fix_new     (m_fix_new),
        .m_latitude_e7 (m_latitude_e7),
        .m_longitude_e7(m_longitude_e7)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------
    rx_item_t    rx_pending_q[$];     // beats still to be offered
    fix_report_t fix_expect_q[$];     // read results predicted, not yet seen

    int cycle_count     = 0;
    int in_beats        = 0;
    int in_stall_cycles = 0;
    int bytes_queued    = 0;
    int reads_queued    = 0;
    int reads_checked   = 0;
    int fixes_handed    = 0;
    int fixes_stored    = 0;
    int mismatches      = 0;
    int gap_left        = 0;
    int stall_left      = 0;
    int hold_left       = 0;
    int holds_done      = 0;
    bit steady          = 1'b0;

    // ------------------------------------------------------------------
    // Parser predictor state, reset values
    // ------------------------------------------------------------------
    int unsigned     line_len    = 0;
    bit              dropping    = 1'b1;
    bit              tag_match   = 1'b0;
    logic [3:0]      field_idx   = '0;
    bit              status_ok   = 1'b0;
    longint unsigned lat_acc     = 0;
    longint unsigned lon_acc     = 0;
    int unsigned     frac_cnt    = 0;
    bit              first_taken = 1'b0;
    bit              south       = 1'b0;
    bit              west        = 1'b0;
    longint          fix_lat     = 0;
    longint          fix_lon     = 0;
    bit              fix_good    = 1'b0;
    bit              fix_unread  = 1'b0;

    function automatic longint unsigned ten_to(input int unsigned n);
        longint unsigned p;
        p = 1;
        repeat (n) p = p * 10;
        return p;
    endfunction

    // Convert a ddmm.mmmmm accumulator into 1e-7 degrees, saturate, apply sign
    function automatic longint e7_degrees(input longint unsigned acc,
                                          input int unsigned frac,
                                          input longint unsigned cap,
                                          input bit negate);
        longint unsigned unit, v, whole, rem, r;
        unit = ten_to(FRAC_DIGITS);
        if (frac > FRAC_DIGITS) frac = FRAC_DIGITS;
        v     = acc * ten_to(FRAC_DIGITS - frac);
        whole = v / (100 * unit);
        rem   = v - whole * 100 * unit;
        r     = whole * 64'd10000000 + (rem * 64'd10000000) / (60 * unit);
        if (r > cap) r = cap;
        return negate ? -longint'(r) : longint'(r);
    endfunction

    task automatic absorb_coord(inout longint unsigned acc, input logic [7:0] ch);
        longint unsigned digit;
        digit = ch - CH_ZERO;
        if (ch == CH_DOT) begin
            first_taken = 1'b1;
        end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            if (!first_taken) begin
                acc = (acc * 10 + digit > COORD_INT_CAP) ? COORD_INT_CAP : acc * 10 + digit;
            end else if (frac_cnt < FRAC_DIGITS) begin
                // drop fraction digits past the kept precision
                acc      = acc * 10 + digit;
                frac_cnt = frac_cnt + 1;
            end
        end
    endtask

    task automatic close_sentence();
        if (tag_match && line_len >= 6) begin
            if (status_ok) begin
                // the fraction count in force at the line end scales both coordinates
                fix_lat     = e7_degrees(lat_acc, frac_cnt, LAT_CAP, south);
                fix_lon     = e7_degrees(lon_acc, frac_cnt, LON_CAP, west);
                fix_good    = 1'b1;
                fix_unread  = 1'b1;
                fixes_stored++;
            end else begin
                fix_good = 1'b0;
            end
        end
    endtask

    // Advance the predictor by one accepted beat; reads queue their result
    task automatic parse_beat(input logic op, input logic [7:0] ch);
        fix_report_t rpt;
        int unsigned pos;
        if (op == OP_READ) begin
            rpt = '0;
            if (fix_unread && fix_good) begin
                rpt.fix_new = 1'b1;
                rpt.lat     = fix_lat[30:0];
                rpt.lon     = fix_lon[31:0];
                fix_unread  = 1'b0;
                fixes_handed++;
            end
            fix_expect_q.push_back(rpt);
        end else if (ch == CH_DOLLAR) begin
            line_len    = 1;
            dropping    = 1'b0;
            tag_match   = 1'b1;
            field_idx   = '0;
            status_ok   = 1'b0;
            lat_acc     = 0;
            lon_acc     = 0;
            frac_cnt    = 0;
            first_taken = 1'b0;
            south       = 1'b0;
            west        = 1'b0;
        end else if (ch == CH_CR || ch == CH_LF) begin
            if (!dropping && line_len > 0) close_sentence();
            line_len = 0;
            dropping = 1'b1;
        end else if (dropping) begin
            // wait for the next dollar
        end else if (line_len >= LINE_MAX - 1) begin
            dropping = 1'b1;
            line_len = 0;
        end else begin
            pos      = line_len;
            line_len = line_len + 1;
            if (pos < 6 && ch != RMC_TAG[47 - 8 * pos -: 8]) tag_match = 1'b0;
            if (ch == CH_COMMA) begin
                if (field_idx != FLD_LAST) field_idx = field_idx + 1'b1;
                first_taken = 1'b0;
                frac_cnt    = 0;
            end else begin
                case (field_idx)
                    FLD_STATUS: begin
                        if (!first_taken) begin
                            if (ch == CH_UPPER_A) status_ok = 1'b1;
                            first_taken = 1'b1;
                        end
                    end
                    FLD_LAT: absorb_coord(lat_acc, ch);
                    FLD_NS: begin
                        if (!first_taken) begin
                            south       = (ch == CH_UPPER_S);
                            first_taken = 1'b1;
                        end
                    end
                    FLD_LON: absorb_coord(lon_acc, ch);
                    FLD_EW: begin
                        if (!first_taken) begin
                            west        = (ch == CH_UPPER_W);
                            first_taken = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    // Mostly short idles, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Printable character that neither starts a sentence nor splits a field
    function automatic logic [7:0] filler_char();
        logic [7:0] c;
        do c = 8'($urandom_range(32, 126)); while (c == CH_DOLLAR || c == CH_COMMA);
        return c;
    endfunction

    function automatic logic [7:0] line_end();
        return $urandom_range(0, 1) ? CH_CR : CH_LF;
    endfunction

    task automatic push_byte(input logic [7:0] ch);
        rx_item_t it;
        it.op = OP_BYTE;
        it.ch = ch;
        rx_pending_q.push_back(it);
        bytes_queued++;
    endtask

    // Reads carry a random byte that the block must ignore
    task automatic push_read();
        rx_item_t it;
        it.op = OP_READ;
        it.ch = 8'($urandom_range(0, 255));
        rx_pending_q.push_back(it);
        reads_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_line(input string s, input logic [7:0] term);
        push_text(s);
        push_byte(term);
    endtask

    task automatic push_digits(input int unsigned n);
        repeat (n) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic push_coord(input int unsigned int_digits, input int unsigned fr_digits);
        push_digits(int_digits);
        if (fr_digits != 0 || $urandom_range(0, 9) == 0) push_byte(CH_DOT);
        push_digits(fr_digits);
        // stray sign, second point or letter inside the number
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: push_byte("-");
                1: push_byte("+");
                2: push_byte(CH_DOT);
                default: push_byte(filler_char());
            endcase
            push_digits($urandom_range(0, 3));
        end
    endtask

    // Well-formed RMC sentence with random content and field count
    task automatic push_rmc_sentence();
        int unsigned nf, fr, r;
        nf = ($urandom_range(0, 99) < 80) ? $urandom_range(2, 8) : $urandom_range(0, 18);
        fr = ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 8);
        push_text("$GPRMC");
        for (int f = 1; f <= nf; f++) begin
            push_byte(CH_COMMA);
            if ($urandom_range(0, 19) == 0) push_read();
            if ($urandom_range(0, 9) == 0) continue;
            case (f)
                1: push_digits($urandom_range(1, 9));
                2: begin
                    r = $urandom_range(0, 99);
                    if (r < 75) push_byte(CH_UPPER_A);
                    else if (r < 88) push_byte("V");
                    else push_byte(filler_char());
                    if ($urandom_range(0, 9) == 0) push_byte(CH_UPPER_A);
                end
                3: push_coord(($urandom_range(0, 3) != 0) ? 4 : $urandom_range(0, 9), fr);
                4: push_byte(($urandom_range(0, 9) == 0) ? filler_char()
                             : ($urandom_range(0, 1) ? "N" : CH_UPPER_S));
                5: push_coord(($urandom_range(0, 3) != 0) ? 5 : $urandom_range(0, 9), fr);
                6: push_byte(($urandom_range(0, 9) == 0) ? filler_char()
                             : ($urandom_range(0, 1) ? "E" : CH_UPPER_W));
                default: repeat ($urandom_range(0, 6)) push_byte(filler_char());
            endcase
        end
        push_byte(line_end());
        if ($urandom_range(0, 4) == 0) push_byte(CH_LF);
        r = $urandom_range(0, 99);
        if (r < 70) push_read();
        else if (r < 85) begin
            push_read();
            push_read();
        end
    endtask

    task automatic build_directed();
        push_read();                                    // nothing stored yet
        push_byte(8'h00);
        push_byte(8'hFF);
        push_line("GPRMC,,A,1,N", CH_LF);               // no leading dollar: ignored
        push_line("$GPRMC,081836,A,4807.03800,N,01131.00000", CH_CR);
        push_byte(CH_LF);
        push_read();
        push_read();                                    // fix handed out only once
        push_line("$GPRMC,,A,4807,S,01131,W", CH_LF);   // south and west negate
        push_read();
        push_line("$GPRMC,,A,9999999.99999999,N,1-8.0.0x59.5,E", CH_LF);
        push_read();                                    // saturated, junk ignored
        push_line("$GPRMC,,A,0000.00000,N,00000.00000", CH_CR);
        push_read();
        push_line("$GPRMC,,A,8959.99999,N,17959.99999", CH_LF);
        push_read();
        push_line("$GPRMC,,A,1234,N,1234,E", CH_LF);
        push_line("$GPRMC,,V,5,N,5,E", CH_LF);          // void clears quality
        push_read();
        push_line("$GPRMC,,,1,N,1,E", CH_LF);           // empty status
        push_read();
        push_line("$GPRMC,,A,12,N,$GPRMC,,A,3000,N,04500,E", CH_CR);  // restart
        push_read();
        push_line("$GPGGA,,A,1,N,1,E", CH_LF);          // other sentence type
        push_read();
        push_line("$GPRMC,,A,2000,N,3000,E", CH_LF);
        push_line("$GPRMC", CH_LF);                     // bare tag clears quality
        push_line("$GPR", CH_CR);                       // too short to count
        push_read();
        push_line("$GPRMC,,A,4500,N,,,,,,,,,,,,,,,,,9", CH_LF);  // comma count saturates
        push_read();
        push_text("$GPRMC,,A,4500,N,");                 // over-long line dropped
        repeat (120) push_byte("7");
        push_byte(CH_LF);
        push_read();
    endtask

    task automatic build_random();
        int unsigned r, bad_pos;
        while (bytes_queued + reads_queued < ITEM_TARGET || reads_queued < READ_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                push_rmc_sentence();
            end else if (r < 77) begin
                // corrupt one character of the tag
                bad_pos = $urandom_range(1, 5);
                for (int i = 0; i < 6; i++)
                    push_byte((i == bad_pos) ? filler_char() : RMC_TAG[47 - 8 * i -: 8]);
                push_line(",,A,4000,N,00100,E", line_end());
                push_read();
            end else if (r < 82) begin
                // straddle the line length limit
                push_text("$GPRMC,,A,1000,N,");
                repeat ($urandom_range(105, 140)) push_byte(filler_char());
                push_byte(line_end());
                push_read();
            end else if (r < 88) begin
                push_text("$GPRMC,");
                push_digits($urandom_range(0, 6));
                if ($urandom_range(0, 1)) push_text(",A,12");
                push_rmc_sentence();
            end else if (r < 95) begin
                repeat ($urandom_range(3, 20)) push_byte(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 3)) push_read();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Free-running cycle count; flip between idling and steady streaming
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 256 == 0) steady <= ($urandom_range(0, 9) < 3);
    end

    // ------------------------------------------------------------------
    // Driver: offer pending beats, hold each until accepted, predict on accept
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_rx
        rx_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                parse_beat(s_operation, s_rx_byte);
                in_beats <= in_beats + 1;
            end else if (s_valid) begin
                in_stall_cycles <= in_stall_cycles + 1;
            end

            if (s_valid && !s_ready) begin
                // hold the beat and its payload
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (rx_pending_q.size() != 0) begin
                nxt = rx_pending_q.pop_front();
                s_valid     <= 1'b1;
                s_operation <= nxt.op;
                s_rx_byte   <= nxt.ch;
                // idle time to insert once this beat is taken
                gap_left    <= (!steady && $urandom_range(0, 99) < 30) ? idle_len() : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off: twice, let the block fill up and stall its input
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && in_beats >= 400 + 500 * holds_done) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // ------------------------------------------------------------------
    // Result ready: random stalls, none while streaming steadily
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_left != 0 || stall_left != 0) begin
            m_ready <= 1'b0;
            if (stall_left != 0) stall_left <= stall_left - 1;
        end else if (!steady && $urandom_range(0, 99) < 25) begin
            m_ready    <= 1'b0;
            stall_left <= idle_len() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result beat with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_fix
        fix_report_t want, got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_fix_new, m_latitude_e7, m_longitude_e7};
            if (fix_expect_q.size() == 0) begin
                if (mismatches < 10)
                    $display("cycle %0d: unexpected result new=%0d lat=%0d lon=%0d",
                             cycle_count, got.fix_new, $signed(got.lat), $signed(got.lon));
                mismatches <= mismatches + 1;
            end else begin
                want = fix_expect_q.pop_front();
                reads_checked <= reads_checked + 1;
                if (got !== want) begin
                    if (mismatches < 10)
                        $display(
                        "cycle %0d: exp new=%0d lat=%0d lon=%0d, got new=%0d lat=%0d lon=%0d",
                            cycle_count, want.fix_new, $signed(want.lat), $signed(want.lon),
                            got.fix_new, $signed(got.lat), $signed(got.lon));
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Timeout
    // ------------------------------------------------------------------
    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles, %0d reads still outstanding",
                 cycle_count, fix_expect_q.size());
        $display("nmea_rmc_position_parser_top regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: build all traffic, release reset, drain, report
    // ------------------------------------------------------------------
    initial begin
        build_directed();
        build_random();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // wait until every beat is taken and every read has answered
        while (rx_pending_q.size() != 0 || s_valid) @(posedge aclk);
        while (fix_expect_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d input beats, %0d reads checked; %0d fixes stored, %0d handed out",
                 in_beats, reads_checked, fixes_stored, fixes_handed);
        $display("input held off for %0d cycles by back-pressure; %0d mismatches",
                 in_stall_cycles, mismatches);
        if (mismatches == 0) begin
            $display("nmea_rmc_position_parser_top regression: pass");
        end else begin
            $display("nmea_rmc_position_parser_top regression: fail");
        end
        $finish;
    end

endmodule
